[rtl/core/cst_pkg.sv]
// Shared types and constants for the counting semaphore table.
// No dependencies; imported by cst_ctrl, cst_dpath, counting_semaphore_table and the testbench.
`default_nettype none

package cst_pkg;

  localparam int NUM_SEMS    = 16;
  localparam int MAX_WAITERS = 16;

  localparam int MODE_W   = 2;
  localparam int SEMIDX_W = 7;
  localparam int VAL_W    = 16;
  localparam int ID_W     = 16;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 18;

  localparam int SEM_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int SLOT_W    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int LEN_W     = $clog2(MAX_WAITERS + 1);
  localparam int MEM_DEPTH = NUM_SEMS * MAX_WAITERS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 2'd0,
    MODE_WAIT    = 2'd1,
    MODE_SIGNAL  = 2'd2,
    MODE_DESTROY = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_NOT_OWNER = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request fields
    logic commit;     // apply decision of the captured request
    logic wake_load;  // present popped waiter, pop the next if draining
  } cst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_pop;  // request releases at least one waiter
    logic more;       // destroy still has waiters after this one
    logic out_free;   // result register can take a transfer this cycle
  } cst_stat_t;

endpackage

`default_nettype wire

[rtl/core/cst_ctrl.sv]
// Sequencer for the counting semaphore table: accept, execute, drain woken waiters.
// Depends on cst_pkg.
`default_nettype none

module cst_ctrl (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  output cst_pkg::cst_cmd_t  cmd,
  input  cst_pkg::cst_stat_t stat
);
  import cst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // a pop goes through the waiter RAM first; plain results need the slot
        if (stat.needs_pop) begin
          cmd.commit = 1'b1;
          state_nxt  = S_WAKE;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_WAKE: begin
        if (stat.out_free) begin
          cmd.wake_load = 1'b1;
          if (!stat.more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/cst_dpath.sv]
// Datapath: semaphore table registers, waiter RAM, decision logic, result register.
// Depends on cst_pkg; driven by cst_ctrl.
`default_nettype none

module cst_dpath (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic [cst_pkg::MODE_W-1:0]   in_mode,
  input  wire                logic [cst_pkg::SEMIDX_W-1:0] in_sem_index,
  input  wire                logic [cst_pkg::VAL_W-1:0]    in_init_value,
  input  wire                logic [cst_pkg::ID_W-1:0]     in_requester_id,
  input  cst_pkg::cst_cmd_t  cmd,
  output cst_pkg::cst_stat_t stat,
  output logic               out_valid,
  input  wire                logic out_ready,
  output logic [cst_pkg::STAT_W-1:0] out_status,
  output logic               out_requester_blocked,
  output logic               out_woken_valid,
  output logic [cst_pkg::ID_W-1:0] out_woken_id,
  output logic               out_woken_aborted,
  output logic               out_last
);
  import cst_pkg::*;

  localparam logic [CNT_W-1:0]  CNT_MAX_V = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WAITERS - 1);

  // captured request
  mode_t             mode_r;
  logic              sem_ok_r;
  logic [SEM_W-1:0]  idx_r;
  logic [VAL_W-1:0]  ival_r;
  logic [ID_W-1:0]   rid_r;

  // table
  logic              in_use_r [NUM_SEMS];
  logic [CNT_W-1:0]  count_r  [NUM_SEMS];
  logic [ID_W-1:0]   owner_r  [NUM_SEMS];
  logic [SLOT_W-1:0] head_r   [NUM_SEMS];
  logic [LEN_W-1:0]  len_r    [NUM_SEMS];

  logic [ID_W-1:0]   waiter_mem [MEM_DEPTH];
  logic [ID_W-1:0]   rd_data_r;

  // result register
  logic              out_valid_r;
  status_t           status_r;
  logic              blocked_r, wvalid_r, aborted_r, last_r;
  logic [ID_W-1:0]   wid_r;

  // entry view and decision
  logic              used;
  logic [CNT_W-1:0]  cnt, cnt_dec, cnt_inc;
  logic [SLOT_W-1:0] hd, hd_next, pop_head;
  logic [LEN_W-1:0]  ln;
  logic [LEN_W:0]    slot_sum;
  logic [SLOT_W-1:0] enq_slot;
  logic [ADDR_W-1:0] base, wr_addr, rd_addr;
  logic              is_destroy;

  status_t           res_status;
  logic              res_blocked, needs_pop;
  logic              do_init, do_enq, do_cnt, do_free, do_head_clr;
  logic [CNT_W-1:0]  cnt_wr;
  logic              commit_apply, pop_now, load_plain;

  assign used       = sem_ok_r && in_use_r[idx_r];
  assign cnt        = count_r[idx_r];
  assign hd         = head_r[idx_r];
  assign ln         = len_r[idx_r];
  assign is_destroy = (mode_r == MODE_DESTROY);

  assign cnt_dec  = cnt - CNT_W'(1);
  assign cnt_inc  = (cnt == CNT_MAX_V) ? cnt : cnt + CNT_W'(1);
  assign hd_next  = (hd == SLOT_LAST) ? '0 : hd + SLOT_W'(1);
  // destroy leaves the head at zero once the queue is drained
  assign pop_head = (is_destroy && ln == LEN_W'(1)) ? '0 : hd_next;

  assign slot_sum = (LEN_W+1)'(hd) + (LEN_W+1)'(ln);
  assign enq_slot = (slot_sum >= (LEN_W+1)'(MAX_WAITERS))
                    ? SLOT_W'(slot_sum - (LEN_W+1)'(MAX_WAITERS)) : SLOT_W'(slot_sum);

  assign base    = ADDR_W'(idx_r) * ADDR_W'(MAX_WAITERS);
  assign wr_addr = base + ADDR_W'(enq_slot);
  assign rd_addr = base + ADDR_W'(hd);

  always_comb begin
    res_status  = ST_OK;
    res_blocked = 1'b0;
    needs_pop   = 1'b0;
    do_init     = 1'b0;
    do_enq      = 1'b0;
    do_cnt      = 1'b0;
    do_free     = 1'b0;
    do_head_clr = 1'b0;
    cnt_wr      = cnt_dec;
    priority if (!sem_ok_r) begin
      res_status = ST_INVALID;
    end else if (mode_r == MODE_INIT) begin
      if (used) begin
        res_status = ST_BUSY;
      end else begin
        do_init = 1'b1;
      end
    end else if (!used) begin
      res_status = ST_INVALID;
    end else begin
      unique case (mode_r)
        MODE_WAIT: begin
          cnt_wr = cnt_dec;
          if (cnt_dec[CNT_W-1]) begin
            if (ln >= LEN_W'(MAX_WAITERS)) begin
              res_status = ST_FULL;
            end else begin
              do_enq      = 1'b1;
              do_cnt      = 1'b1;
              res_blocked = 1'b1;
            end
          end else begin
            do_cnt = 1'b1;
          end
        end
        MODE_SIGNAL: begin
          cnt_wr    = cnt_inc;
          do_cnt    = 1'b1;
          needs_pop = (cnt_inc[CNT_W-1] || cnt_inc == '0) && ln != '0;
        end
        MODE_DESTROY: begin
          if (owner_r[idx_r] != rid_r) begin
            res_status = ST_NOT_OWNER;
          end else begin
            do_free     = 1'b1;
            needs_pop   = (ln != '0);
            do_head_clr = (ln == '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.needs_pop = needs_pop;
  assign stat.more      = is_destroy && ln != '0;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign commit_apply = cmd.commit;
  assign pop_now      = (cmd.commit && needs_pop) || (cmd.wake_load && stat.more);
  assign load_plain   = cmd.commit && !needs_pop;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= mode_t'(in_mode);
      sem_ok_r <= (in_sem_index < SEMIDX_W'(NUM_SEMS));
      idx_r    <= in_sem_index[SEM_W-1:0];
      ival_r   <= in_init_value;
      rid_r    <= in_requester_id;
    end
  end

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        in_use_r[i] <= 1'b0;
        head_r[i]   <= '0;
        len_r[i]    <= '0;
      end
    end else begin
      if (commit_apply && do_init) begin
        in_use_r[idx_r] <= 1'b1;
        head_r[idx_r]   <= '0;
        len_r[idx_r]    <= '0;
      end
      if (commit_apply && do_free) begin
        in_use_r[idx_r] <= 1'b0;
      end
      if (commit_apply && do_head_clr) begin
        head_r[idx_r] <= '0;
      end
      if (commit_apply && do_enq) begin
        len_r[idx_r] <= ln + LEN_W'(1);
      end
      if (pop_now) begin
        head_r[idx_r] <= pop_head;
        len_r[idx_r]  <= ln - LEN_W'(1);
      end
    end
  end

  // table payload
  always_ff @(posedge clk) begin
    if (commit_apply && do_init) begin
      count_r[idx_r] <= CNT_W'(ival_r);
      owner_r[idx_r] <= rid_r;
    end
    if (commit_apply && do_cnt) begin
      count_r[idx_r] <= cnt_wr;
    end
  end

  // waiter RAM, registered read
  always_ff @(posedge clk) begin
    if (commit_apply && do_enq) begin
      waiter_mem[wr_addr] <= rid_r;
    end
    if (pop_now) begin
      rd_data_r <= waiter_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_plain || cmd.wake_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_plain) begin
      status_r  <= res_status;
      blocked_r <= res_blocked;
      wvalid_r  <= 1'b0;
      wid_r     <= '0;
      aborted_r <= 1'b0;
      last_r    <= 1'b1;
    end else if (cmd.wake_load) begin
      status_r  <= ST_OK;
      blocked_r <= 1'b0;
      wvalid_r  <= 1'b1;
      wid_r     <= rd_data_r;
      aborted_r <= is_destroy;
      last_r    <= !stat.more;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_requester_blocked = blocked_r;
  assign out_woken_valid       = wvalid_r;
  assign out_woken_id          = wid_r;
  assign out_woken_aborted     = aborted_r;
  assign out_last              = last_r;

endmodule

`default_nettype wire

[rtl/core/counting_semaphore_table.sv]
// Top level of the counting semaphore table: controller plus datapath.
// Depends on cst_pkg, cst_ctrl and cst_dpath.
//
// Usage
//   Requests arrive on the in_ channel (valid/ready): operation, semaphore
//   index, initial value and the caller's task id. Results leave on the
//   out_ channel (valid/ready), one transfer per result; out_last marks the
//   final result of a request.
//   Init, wait and signal without a release give one result; a signal that
//   releases a waiter gives one result carrying the woken id; a destroy by
//   the owner gives one result per queued waiter, oldest first, each marked
//   aborted (or a single plain result when nobody waits).
// Timing
//   One request at a time. A request without a release is accepted in S_IDLE,
//   decided in S_EXEC and the block is ready again. A release reads the waiter
//   RAM (registered read port) in S_EXEC, so a signal that wakes a task passes
//   through S_WAKE, and a destroy drains its waiters in S_WAKE, one waiter per
//   cycle while the result register is free. Results are registered.
// Reset
//   rst_n (synchronous, active low) frees every entry and empties every
//   queue; no clearing pass is needed, the block is ready straight after.
// Back-pressure
//   The result register holds a finished result while the receiver stalls;
//   the next request is still accepted and waits in its decision step (a release
//   in its wake step) until the register frees up.
`default_nettype none

module counting_semaphore_table (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  logic [cst_pkg::MODE_W-1:0]   in_mode,
  input  wire  logic [cst_pkg::SEMIDX_W-1:0] in_sem_index,
  input  wire  logic [cst_pkg::VAL_W-1:0]    in_init_value,
  input  wire  logic [cst_pkg::ID_W-1:0]     in_requester_id,
  output logic       out_valid,
  input  wire  logic out_ready,
  output logic [cst_pkg::STAT_W-1:0] out_status,
  output logic       out_requester_blocked,
  output logic       out_woken_valid,
  output logic [cst_pkg::ID_W-1:0]   out_woken_id,
  output logic       out_woken_aborted,
  output logic       out_last
);
  import cst_pkg::*;

  cst_cmd_t  cmd;   // sequencing commands
  cst_stat_t stat;  // decision flags back to the sequencer

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cst_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_mode               (in_mode),
    .in_sem_index          (in_sem_index),
    .in_init_value         (in_init_value),
    .in_requester_id       (in_requester_id),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_requester_blocked (out_requester_blocked),
    .out_woken_valid       (out_woken_valid),
    .out_woken_id          (out_woken_id),
    .out_woken_aborted     (out_woken_aborted),
    .out_last              (out_last)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for counting_semaphore_table: stimulus queue, driver, monitor
// and a predictor of the semaphore table. Depends on cst_pkg and the RTL top level.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int CNT_TOP      = (1 << (CNT_W - 1)) - 1;  // saturation limit, 131071
  localparam int IDLE_PCT     = 14;
  localparam int RANDOM_REQS  = 300;
  localparam int RX_HOLD      = 80;         // long receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_REPORTS  = 20;

  // One request as the driver presents it; quiet and hold_rx steer the idling.
  typedef struct {
    mode_t                mode;
    logic [SEMIDX_W-1:0]  idx;
    logic [VAL_W-1:0]     ival;
    logic [ID_W-1:0]      rid;
    bit                   quiet;
    bit                   hold_rx;
  } sem_req_t;

  typedef struct {
    status_t          status;
    logic             blocked;
    logic             woken;
    logic [ID_W-1:0]  woken_id;
    logic             aborted;
    logic             last;
  } sem_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [SEMIDX_W-1:0]  in_sem_index = '0;
  logic [VAL_W-1:0]     in_init_value = '0;
  logic [ID_W-1:0]      in_requester_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic                 out_requester_blocked;
  logic                 out_woken_valid;
  logic [ID_W-1:0]      out_woken_id;
  logic                 out_woken_aborted;
  logic                 out_last;

  counting_semaphore_table DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_sem_index          (in_sem_index),
    .in_init_value         (in_init_value),
    .in_requester_id       (in_requester_id),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_requester_blocked (out_requester_blocked),
    .out_woken_valid       (out_woken_valid),
    .out_woken_id          (out_woken_id),
    .out_woken_aborted     (out_woken_aborted),
    .out_last              (out_last)
  );

  // ---------------------------------------------------------------------------
  // Predicted semaphore table: mirrors the block's state, updated per accepted
  // request transfer in acceptance order.
  // ---------------------------------------------------------------------------
  bit                      sem_live  [NUM_SEMS];
  logic signed [CNT_W-1:0] sem_count [NUM_SEMS];
  logic [ID_W-1:0]         sem_owner [NUM_SEMS];
  logic [ID_W-1:0]         wait_fifo [NUM_SEMS][MAX_WAITERS];
  logic [SLOT_W-1:0]       fifo_head [NUM_SEMS];
  logic [LEN_W-1:0]        fifo_len  [NUM_SEMS];

  sem_req_t    pending_reqs[$];   // requests not yet offered
  sem_result_t due_results[$];    // results predicted but not yet seen

  int unsigned mismatches = 0;
  int unsigned reqs_taken = 0;
  int unsigned results_seen = 0;
  int unsigned wakes_seen = 0;
  int unsigned aborts_seen = 0;
  int unsigned full_seen = 0;
  int unsigned cycles = 0;

  bit quiet_run = 1'b0;    // set while the current request belongs to the no-idle stretch
  bit rx_hold_req = 1'b0;  // driver asks the monitor for its long hold-off
  bit rx_hold_done = 1'b0;
  int unsigned rx_hold_left = 0;

  function automatic void push_due(status_t st, logic blk, logic wv, logic [ID_W-1:0] wid,
                                   logic ab, logic lst);
    sem_result_t r;
    r.status   = st;
    r.blocked  = blk;
    r.woken    = wv;
    r.woken_id = wid;
    r.aborted  = ab;
    r.last     = lst;
    due_results.push_back(r);
  endfunction

  function automatic logic [ID_W-1:0] pop_waiter(int s);
    logic [ID_W-1:0] id;
    id = wait_fifo[s][fifo_head[s]];
    fifo_head[s] = fifo_head[s] + 1'b1;
    fifo_len[s]  = fifo_len[s] - 1'b1;
    return id;
  endfunction

  // Works out the results of one request and advances the predicted table.
  function automatic void predict_sem_op(mode_t m, logic [SEMIDX_W-1:0] idx,
                                         logic [VAL_W-1:0] ival, logic [ID_W-1:0] rid);
    int s;
    int c;
    logic [ID_W-1:0] id;
    s = idx;
    if (idx >= NUM_SEMS) begin
      push_due(ST_INVALID, 1'b0, 1'b0, '0, 1'b0, 1'b1);
    end else if (m == MODE_INIT) begin
      if (sem_live[s]) begin
        push_due(ST_BUSY, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end else begin
        sem_live[s]  = 1'b1;
        sem_count[s] = CNT_W'(ival);
        sem_owner[s] = rid;
        fifo_head[s] = '0;
        fifo_len[s]  = '0;
        push_due(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end
    end else if (!sem_live[s]) begin
      push_due(ST_INVALID, 1'b0, 1'b0, '0, 1'b0, 1'b1);
    end else if (m == MODE_WAIT) begin
      c = int'(sem_count[s]) - 1;
      if (c >= 0) begin
        sem_count[s] = CNT_W'(c);
        push_due(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end else if (fifo_len[s] >= MAX_WAITERS) begin
        // queue full: counter and queue stay as they are
        push_due(ST_FULL, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end else begin
        wait_fifo[s][SLOT_W'(fifo_head[s] + fifo_len[s])] = rid;
        fifo_len[s]  = fifo_len[s] + 1'b1;
        sem_count[s] = CNT_W'(c);
        push_due(ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
      end
    end else if (m == MODE_SIGNAL) begin
      c = int'(sem_count[s]);
      if (c < CNT_TOP) c++;
      sem_count[s] = CNT_W'(c);
      if (c <= 0 && fifo_len[s] > 0) begin
        id = pop_waiter(s);
        push_due(ST_OK, 1'b0, 1'b1, id, 1'b0, 1'b1);
      end else begin
        push_due(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end
    end else if (sem_owner[s] != rid) begin
      push_due(ST_NOT_OWNER, 1'b0, 1'b0, '0, 1'b0, 1'b1);
    end else begin
      // destroy by the owner: every waiter released, oldest first, as aborted
      sem_live[s] = 1'b0;
      if (fifo_len[s] == 0) begin
        push_due(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end else begin
        while (fifo_len[s] > 0) begin
          id = pop_waiter(s);
          push_due(ST_OK, 1'b0, 1'b1, id, 1'b1, fifo_len[s] == 0);
        end
      end
      fifo_head[s] = '0;
    end
  endfunction

  function automatic void queue_req(mode_t m, int unsigned idx, int unsigned ival,
                                    int unsigned rid, bit quiet = 1'b0, bit hold_rx = 1'b0);
    sem_req_t r;
    r.mode    = m;
    r.idx     = SEMIDX_W'(idx);
    r.ival    = VAL_W'(ival);
    r.rid     = ID_W'(rid);
    r.quiet   = quiet;
    r.hold_rx = hold_rx;
    pending_reqs.push_back(r);
  endfunction

  function automatic void flag_mismatch(string field, int unsigned exp_v, int unsigned act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: result %0d field %s mismatch: expected %0d, actual %0d",
               $realtime, results_seen, field, exp_v, act_v);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: stops the run as a failure once the cycle count passes LIMIT_CYCLES.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, due_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests on the in_ channel. Prediction runs on each
  // accepted transfer; the next request (or a gap) is set up in the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sem_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sem_op(mode_t'(in_mode), in_sem_index, in_init_value, in_requester_id);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 &&
            (pending_reqs[0].quiet || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_reqs.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= nxt.mode;
          in_sem_index    <= nxt.idx;
          in_init_value   <= nxt.ival;
          in_requester_id <= nxt.rid;
          quiet_run       <= nxt.quiet;
          if (nxt.hold_rx) rx_hold_req <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result transfer against the oldest prediction and
  // drives out_ready, including one long hold-off so the block backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sem_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_woken_valid && !out_woken_aborted) wakes_seen++;
        if (out_woken_aborted) aborts_seen++;
        if (out_status == ST_FULL) full_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual status %0d woken %0d id %0d",
                     $realtime, out_status, out_woken_valid, out_woken_id);
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", want.status, out_status);
          if (out_requester_blocked !== want.blocked)
            flag_mismatch("requester_blocked", want.blocked, out_requester_blocked);
          if (out_woken_valid !== want.woken)
            flag_mismatch("woken_valid", want.woken, out_woken_valid);
          if (out_woken_id !== want.woken_id)
            flag_mismatch("woken_id", want.woken_id, out_woken_id);
          if (out_woken_aborted !== want.aborted)
            flag_mismatch("woken_aborted", want.aborted, out_woken_aborted);
          if (out_last !== want.last)
            flag_mismatch("last", want.last, out_last);
        end
      end
      if (rx_hold_req && !rx_hold_done) begin
        rx_hold_left = RX_HOLD;
        rx_hold_done = 1'b1;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned idx;
    int unsigned ival;
    int unsigned rid;
    int unsigned id_pool[3];
    mode_t m;

    foreach (sem_live[i]) begin
      sem_live[i]  = 1'b0;
      sem_count[i] = '0;
      sem_owner[i] = '0;
      fifo_head[i] = '0;
      fifo_len[i]  = '0;
    end

    // Directed: bad index, unused entry, busy init, block and wake, wrong owner,
    // destroy with and without waiters.
    queue_req(MODE_INIT,    16,  0,     16'h1111);
    queue_req(MODE_WAIT,    127, 16'hFFFF, 16'hFFFF);
    queue_req(MODE_WAIT,    5,   0,     16'h0005);
    queue_req(MODE_SIGNAL,  5,   0,     16'h0005);
    queue_req(MODE_DESTROY, 5,   0,     16'h0005);
    queue_req(MODE_INIT,    0,   0,     16'hFFFF);
    queue_req(MODE_INIT,    0,   3,     16'h0000);
    queue_req(MODE_WAIT,    0,   0,     16'h0001);
    queue_req(MODE_WAIT,    0,   0,     16'h8000);
    queue_req(MODE_SIGNAL,  0,   0,     16'h0002);
    queue_req(MODE_DESTROY, 0,   0,     16'h1234);
    queue_req(MODE_DESTROY, 0,   0,     16'hFFFF);
    queue_req(MODE_INIT,    15,  1,     16'h0000);
    queue_req(MODE_WAIT,    15,  0,     16'h0007);
    queue_req(MODE_SIGNAL,  15,  0,     16'h0007);
    queue_req(MODE_DESTROY, 15,  0,     16'h0000);

    // Queue full: sixteen waiters, a seventeenth refused, then a full drain.
    queue_req(MODE_INIT, 3, 0, 16'hA5A5);
    for (int i = 0; i <= MAX_WAITERS; i++)
      queue_req(MODE_WAIT, 3, 0, 16'h1000 + i * 16'h0111);
    queue_req(MODE_DESTROY, 3, 0, 16'hA5A5);

    // Counter above 16 bits: a few signals past the largest init value, then a wait
    // and a destroy by the owner.
    queue_req(MODE_INIT, 7, 16'hFFFF, 16'h5A5A);
    for (int i = 0; i < 4; i++)
      queue_req(MODE_SIGNAL, 7, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
    queue_req(MODE_WAIT, 7, 0, 16'h0042);
    queue_req(MODE_DESTROY, 7, 0, 16'h5A5A);

    // Random: mostly a few entries and a small pool of task ids so owners match
    // and queues grow; the rest spreads over every index and id.
    foreach (id_pool[i]) id_pool[i] = $urandom_range(16'hFFFF);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(99);
      m = (r < 15) ? MODE_INIT : (r < 50) ? MODE_WAIT : (r < 85) ? MODE_SIGNAL : MODE_DESTROY;
      r = $urandom_range(99);
      idx = (r < 70) ? $urandom_range(3) :
            (r < 90) ? $urandom_range(NUM_SEMS - 1, 4) : $urandom_range(127, NUM_SEMS);
      r = $urandom_range(99);
      ival = (r < 60) ? $urandom_range(2) : (r < 90) ? $urandom_range(16'hFFFF) : 16'hFFFF;
      rid = ($urandom_range(99) < 75) ? id_pool[$urandom_range(2)] : $urandom_range(16'hFFFF);
      queue_req(m, idx, ival, rid, (i >= 120 && i < 200), (i == 250));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || due_results.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (due_results.size() > 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $realtime, due_results.size());
    end

    $display("Covered %0d requests, %0d results: %0d wakes, %0d aborted releases, %0d full",
             reqs_taken, results_seen, wakes_seen, aborts_seen, full_seen);
    $display("Counter taken past 16 bits, long receiver stall included; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/cst_pkg.sv
rtl/core/cst_ctrl.sv
rtl/core/cst_dpath.sv
rtl/core/counting_semaphore_table.sv
dv/testbench.sv
